FILE: rtl/modular_exponentiation_assert.svh
// assertion macros shared by the modular exponentiation block
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MEXP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("modexp check failed");

// next-cycle implication, checked out of reset
`define MEXP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("modexp check failed");

`endif

FILE: rtl/mexp_pkg.sv
// types and constants of the modular exponentiation block
package mexp_pkg;

   // width of modulus, base and result
   localparam int WORD_BITS = 31;
   // default number of exponent bits that take part
   localparam int EXP_BITS_DEFAULT = 63;
   // modulus after reset
   localparam logic [WORD_BITS-1:0] MODULUS_RESET = 31'd1000000007;
   // one multiplier bit per step of the modular multiplier
   localparam int MM_STEPS = WORD_BITS;

   // command codes on req_command
   localparam logic CMD_POWER   = 1'b0;
   localparam logic CMD_INVERSE = 1'b1;

   // launch of one modular product
   typedef struct packed {
      logic                 start;
      logic [WORD_BITS-1:0] addend;
      logic [WORD_BITS-1:0] multiplier;
   } mm_req_type;

   // status and product of the modular multiplier
   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [WORD_BITS-1:0] product;
   } mm_rsp_type;

endpackage

FILE: rtl/modular_exponentiation.sv
// modular exponentiation top level: register, sequencer and checks
//
// Usage
//   An item (req_command, req_base, req_exponent) is taken at a rising edge with
//   start high and busy low. Command 0 raises the base to the exponent, command 1
//   uses the modulus minus two as exponent (inverse for a prime modulus).
//   Only the low EXP_BITS exponent bits take part.
//   The result shows on rsp_result for one cycle with rsp_strobe high; the
//   receiver cannot hold it off, and busy is low again in that cycle. The
//   modulus must be written through csr_wr_en / csr_wr_data only while idle;
//   the block itself does not enforce this.
// Sequence
//   All products go through one bit-serial modular multiplier. The base is
//   reduced first; each exponent bit down to and including the leading one
//   is only scanned, each bit below it takes a square and, when set, a
//   multiply, and a final check ends the run. A modulus below two gives 0
//   on the cycle after the transfer.
// Reset
//   Synchronous reset returns the sequencer to idle and sets the modulus to
//   1000000007; no result is pending afterwards.
`include "modular_exponentiation_assert.svh"

module modular_exponentiation #(
   parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_command,
   input  logic [mexp_pkg::WORD_BITS-1:0] req_base,
   input  logic [62:0]                    req_exponent,
   input  logic                           csr_wr_en,
   input  logic [mexp_pkg::WORD_BITS-1:0] csr_wr_data,
   output logic                           rsp_strobe,
   output logic [mexp_pkg::WORD_BITS-1:0] rsp_result
);

   localparam int W  = mexp_pkg::WORD_BITS;
   localparam int BW = $clog2(EXP_BITS + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_SQUARE = 3'd3;
   localparam logic [2:0] ST_MULT   = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [W-1:0]        mod_ff, mod_in;
   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic [BW-1:0]       bcnt_ff, bcnt_in;
   logic [W-1:0]        bb_ff, bb_in;
   logic [W-1:0]        acc_ff, acc_in;
   logic                started_ff, started_in;
   logic                pend_ff, pend_in;
   logic                strobe_ff, strobe_in;
   logic [W-1:0]        result_ff, result_in;

   logic [63:0]         exp_full;
   logic                accept;

   mexp_pkg::mm_req_type mm_req;
   mexp_pkg::mm_rsp_type mm_rsp;

   mexp_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .modulus (mod_ff),
      .mm_req  (mm_req),
      .mm_rsp  (mm_rsp)
   );

   assign accept = start && (state_ff == ST_IDLE);

   // exponent of the item, inverse takes modulus minus two
   always_comb begin
      if (req_command == mexp_pkg::CMD_INVERSE) begin
         exp_full = {33'd0, mod_ff - W'(2)};
      end else begin
         exp_full = {1'b0, req_exponent};
      end
   end

   // modulus register
   always_comb begin
      mod_in = mod_ff;
      if (csr_wr_en) begin
         mod_in = csr_wr_data;
      end
   end

   // square-and-multiply sequencer
   always_comb begin
      state_in          = state_ff;
      exp_in            = exp_ff;
      bcnt_in           = bcnt_ff;
      bb_in             = bb_ff;
      acc_in            = acc_ff;
      started_in        = started_ff;
      pend_in           = pend_ff;
      strobe_in         = 1'b0;
      result_in         = result_ff;
      mm_req.start      = 1'b0;
      mm_req.addend     = acc_ff;
      mm_req.multiplier = acc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (mod_ff < W'(2)) begin
                  strobe_in = 1'b1;
                  result_in = '0;
               end else begin
                  exp_in            = exp_full[EXP_BITS-1:0];
                  bcnt_in           = '0;
                  started_in        = 1'b0;
                  mm_req.start      = 1'b1;
                  mm_req.addend     = W'(1);
                  mm_req.multiplier = req_base;
                  state_in          = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mm_rsp.done) begin
               bb_in    = mm_rsp.product;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (bcnt_ff == BW'(EXP_BITS)) begin
               strobe_in = 1'b1;
               result_in = started_ff ? acc_ff : W'(1);
               state_in  = ST_IDLE;
            end else begin
               exp_in  = exp_ff << 1;
               bcnt_in = bcnt_ff + 1'b1;
               if (!started_ff) begin
                  // leading zeros leave the running value at one
                  if (exp_ff[EXP_BITS-1]) begin
                     acc_in     = bb_ff;
                     started_in = 1'b1;
                  end
               end else begin
                  pend_in      = exp_ff[EXP_BITS-1];
                  mm_req.start = 1'b1;
                  state_in     = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            if (mm_rsp.done) begin
               acc_in = mm_rsp.product;
               if (pend_ff) begin
                  mm_req.start      = 1'b1;
                  mm_req.addend     = mm_rsp.product;
                  mm_req.multiplier = bb_ff;
                  state_in          = ST_MULT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_MULT: begin
            if (mm_rsp.done) begin
               acc_in   = mm_rsp.product;
               state_in = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         mod_ff    <= mexp_pkg::MODULUS_RESET;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         mod_ff    <= mod_in;
         strobe_ff <= strobe_in;
      end
      exp_ff     <= exp_in;
      bcnt_ff    <= bcnt_in;
      bb_ff      <= bb_in;
      acc_ff     <= acc_in;
      started_ff <= started_in;
      pend_ff    <= pend_in;
      result_ff  <= result_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_result = result_ff;

   // checks
   `MEXP_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_strobe)
   `MEXP_ASSERT_SAME(a_launch_when_free, clock, reset, mm_req.start, !mm_rsp.busy)
   `MEXP_ASSERT_NEXT(a_done_single, clock, reset, mm_rsp.done, !mm_rsp.done)

endmodule

FILE: rtl/mexp_mulmod.sv
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
module mexp_mulmod (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [mexp_pkg::WORD_BITS-1:0]      modulus,
   input  mexp_pkg::mm_req_type                mm_req,
   output mexp_pkg::mm_rsp_type                mm_rsp
);

   localparam int W   = mexp_pkg::WORD_BITS;
   localparam int CW  = $clog2(mexp_pkg::MM_STEPS);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  y_ff, y_in;
   logic [W-1:0]  r_ff, r_in;

   logic [W+2:0]  sum;
   logic [W+2:0]  diff1;
   logic [W+2:0]  diff2;

   // double and add, then take off the modulus once or twice
   always_comb begin
      sum   = {2'b00, r_ff, 1'b0} + (y_ff[W-1] ? {3'b000, x_ff} : '0);
      diff1 = sum - {3'b000, modulus};
      diff2 = sum - {2'b00, modulus, 1'b0};
   end

   // step sequencing
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      r_in    = r_ff;
      if (busy_ff) begin
         y_in   = y_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (!diff2[W+2]) begin
            r_in = diff2[W-1:0];
         end else if (!diff1[W+2]) begin
            r_in = diff1[W-1:0];
         end else begin
            r_in = sum[W-1:0];
         end
         if (cnt_ff == CW'(mexp_pkg::MM_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (mm_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = mm_req.addend;
         y_in    = mm_req.multiplier;
         r_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      r_ff <= r_in;
   end

   assign mm_rsp.busy    = busy_ff;
   assign mm_rsp.done    = done_ff;
   assign mm_rsp.product = r_ff;

endmodule
